/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define SLI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SLI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SLI_ASSERT(lbl, clk, rst_n, prop, msg)
`define SLI_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* src/sli_pkg.sv */
// ----------------------------------------------------------------------------
// sli_pkg
// Types and constants shared by the sorted insertion list.
// ----------------------------------------------------------------------------
package sli_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 5;
    localparam int MAX_OUT = 32;

    localparam logic [1:0] MODE_INSERT    = 2'd0;
    localparam logic [1:0] MODE_DUMP_ASC  = 2'd1;
    localparam logic [1:0] MODE_DUMP_DESC = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } t_state;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic                      ins;
        logic                      rot_l;
        logic                      rot_r;
        logic signed [VALUE_W-1:0] value;
    } t_cell_ctrl;

endpackage

/* src/sorted_list_insert_top.sv */
// ----------------------------------------------------------------------------
// sorted_list_insert_top
// Bounded ascending list of signed values held in a chain of cells.
// ----------------------------------------------------------------------------
// An insert is accepted while the block is idle and inserts may follow back
// to back: every cell compares in parallel and the tail shifts one place. A
// dump rotates the whole chain of DEPTH cells once, one place per cycle unless
// the output stalls, and emits at most one item per cycle from the chain end;
// no input is taken during a dump. A dump of an empty list emits a single item
// flagged empty. Inserts into a full list are dropped and set a sticky
// overflow flag reported on every output item.
`include "assert_macros.svh"

module sorted_list_insert_top #(
    parameter int DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] item_value, [36:32] position
    output logic [1:0]  m_axis_tuser,   // [0] list_empty, [1] overflowed
    output logic        m_axis_tlast
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int XW = ((CW > 6) ? CW : 6) + 1;
    localparam int VW = sli_pkg::VALUE_W;

    sli_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [IW-1:0]   r_step, n_step;
    logic            r_desc, n_desc;
    logic            r_ovf, n_ovf;

    logic                 r_out_valid;
    logic signed [VW-1:0] r_out_value;
    logic [4:0]           r_out_pos;
    logic                 r_out_empty;
    logic                 r_out_ovf;
    logic                 r_out_last;

    sli_pkg::t_cell_ctrl  w_ctrl;
    logic                 w_lt  [DEPTH];
    logic signed [VW-1:0] w_val [DEPTH];

    logic          w_accept;
    logic          w_out_free;
    logic          w_emit;
    logic          w_last;
    logic          w_advance;
    logic          w_load;
    logic [XW-1:0] w_cnt_x, w_step_x, w_pos_x, w_emit_n;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;

    // dump bookkeeping
    always_comb begin
        w_cnt_x  = XW'(r_count);
        w_step_x = XW'(r_step);
        w_emit_n = (w_cnt_x < XW'(sli_pkg::MAX_OUT)) ? w_cnt_x : XW'(sli_pkg::MAX_OUT);
        if (r_desc) begin
            w_pos_x = XW'(DEPTH - 1) - w_step_x;
            w_emit  = (w_pos_x < w_cnt_x)
                   && ((w_pos_x + XW'(sli_pkg::MAX_OUT)) >= w_cnt_x);
            w_last  = (w_pos_x == (w_cnt_x - w_emit_n));
        end else begin
            w_pos_x = w_step_x;
            w_emit  = (w_step_x < w_emit_n);
            w_last  = (w_step_x == (w_emit_n - XW'(1)));
        end
        if (r_count == '0) begin
            w_emit = 1'b1;
            w_last = 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sli_pkg::ST_IDLE: begin
                if (w_accept && (s_axis_tuser == sli_pkg::MODE_DUMP_ASC
                              || s_axis_tuser == sli_pkg::MODE_DUMP_DESC)) begin
                    n_state = sli_pkg::ST_DUMP;
                end
            end
            sli_pkg::ST_DUMP: begin
                if (w_advance && ((r_count == '0) || (r_step == IW'(DEPTH - 1)))) begin
                    n_state = sli_pkg::ST_IDLE;
                end
            end
            default: n_state = sli_pkg::ST_IDLE;
        endcase
    end

    // state machine outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_advance     = 1'b0;
        w_ctrl.ins    = 1'b0;
        w_ctrl.rot_l  = 1'b0;
        w_ctrl.rot_r  = 1'b0;
        w_ctrl.value  = s_axis_tdata;
        unique case (r_state)
            sli_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                w_ctrl.ins    = w_accept && (s_axis_tuser == sli_pkg::MODE_INSERT)
                             && (r_count != CW'(DEPTH));
            end
            sli_pkg::ST_DUMP: begin
                w_advance    = !w_emit || w_out_free;
                w_ctrl.rot_l = w_advance && !r_desc && (r_count != '0);
                w_ctrl.rot_r = w_advance && r_desc && (r_count != '0);
            end
            default: ;
        endcase
    end

    assign w_load = w_advance && w_emit;

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        n_step  = r_step;
        n_desc  = r_desc;
        if (w_ctrl.ins) begin
            n_count = r_count + CW'(1);
        end
        if (r_state == sli_pkg::ST_IDLE && w_accept
                && s_axis_tuser == sli_pkg::MODE_INSERT && r_count == CW'(DEPTH)) begin
            n_ovf = 1'b1;
        end
        if (r_state == sli_pkg::ST_IDLE) begin
            n_step = '0;
            n_desc = (s_axis_tuser == sli_pkg::MODE_DUMP_DESC);
        end else if (w_advance) begin
            n_step = r_step + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sli_pkg::ST_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_step      <= '0;
            r_desc      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_step      <= n_step;
            r_desc      <= n_desc;
            r_out_valid <= w_load ? 1'b1 : (m_axis_tready ? 1'b0 : r_out_valid);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_empty <= (r_count == '0);
            r_out_ovf   <= r_ovf;
            r_out_last  <= w_last;
            if (r_count == '0) begin
                r_out_value <= '0;
                r_out_pos   <= '0;
            end else begin
                r_out_value <= r_desc ? w_val[DEPTH-1] : w_val[0];
                r_out_pos   <= 5'(w_pos_x);
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        sli_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_valid    (CW'(g) < r_count),
            .i_prev_lt  ((g == 0) ? 1'b1 : w_lt[(g + DEPTH - 1) % DEPTH]),
            .i_prev_val (w_val[(g + DEPTH - 1) % DEPTH]),
            .i_next_val (w_val[(g + 1) % DEPTH]),
            .o_lt       (w_lt[g]),
            .o_val      (w_val[g])
        );
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_pos, r_out_value};
    assign m_axis_tuser  = {r_out_ovf, r_out_empty};
    assign m_axis_tlast  = r_out_last;

    `SLI_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "count above depth")
    `SLI_ASSERT(a_no_take_in_dump, i_clk, i_rst_n, (r_state == sli_pkg::ST_DUMP) |-> !s_axis_tready, "input taken during dump")
    `SLI_ASSERT(a_insert_grows, i_clk, i_rst_n, (w_ctrl.ins) |=> (r_count == $past(r_count) + CW'(1)), "insert did not grow list")
    `SLI_ASSERT(a_ovf_sticky, i_clk, i_rst_n, r_ovf |=> r_ovf, "overflow flag cleared")
    `SLI_ASSERT(a_load_free, i_clk, i_rst_n, w_load |-> w_out_free, "output overwritten")

endmodule

/* src/sli_cell.sv */
// ----------------------------------------------------------------------------
// sli_cell
// One list cell: compare against the inserted value, keep, load or shift.
// ----------------------------------------------------------------------------
module sli_cell (
    input  logic                                i_clk,
    input  sli_pkg::t_cell_ctrl                 i_ctrl,
    input  logic                                i_valid,
    input  logic                                i_prev_lt,
    input  logic signed [sli_pkg::VALUE_W-1:0]  i_prev_val,
    input  logic signed [sli_pkg::VALUE_W-1:0]  i_next_val,
    output logic                                o_lt,
    output logic signed [sli_pkg::VALUE_W-1:0]  o_val
);

    logic signed [sli_pkg::VALUE_W-1:0] r_val;
    logic signed [sli_pkg::VALUE_W-1:0] n_val;

    assign o_lt  = i_valid && (r_val < i_ctrl.value);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctrl.ins) begin
            if (!o_lt) begin
                n_val = i_prev_lt ? i_ctrl.value : i_prev_val;
            end
        end else if (i_ctrl.rot_l) begin
            n_val = i_next_val;
        end else if (i_ctrl.rot_r) begin
            n_val = i_prev_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule
